[rtl/core/hwmq_pkg.sv]
// Shared types and constants for the histogram with mode query block.
// No dependencies; imported by hwmq_ctrl, histogram_with_mode_query and the testbench.
`timescale 1ns / 1ps

package hwmq_pkg;

    // Field widths of the stream words and config registers
    localparam int OPCODE_W      = 2;
    localparam int BIN_INDEX_W   = 9;
    localparam int MODE_STATE_W  = 9;
    localparam int MODE_COUNT_W  = 32;
    localparam int BINS_IN_USE_W = 9;
    localparam int CLEAR_VALUE_W = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 48;

    // Operation codes carried in the input word
    typedef enum logic [OPCODE_W-1:0] {
        OP_RECORD = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    // Config register indexes
    typedef enum logic {
        CFG_BINS_IN_USE = 1'b0,
        CFG_CLEAR_VALUE = 1'b1
    } cfg_index_t;

    // Live configuration handed to the sequencer
    typedef struct packed {
        logic [BINS_IN_USE_W-1:0] bins_in_use;
        logic [CLEAR_VALUE_W-1:0] clear_value;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic                    status;
        logic [MODE_COUNT_W-1:0] mode_count;
        logic [MODE_STATE_W-1:0] mode_state;
    } result_t;

endpackage

[rtl/core/hwmq_bin_mem.sv]
// Bin counter storage: single write port, single read port, registered read.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module hwmq_bin_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/hwmq_ctrl.sv]
// Sequencer: reset sweep, record read-modify-write, clear walk, query scan.
// Depends on hwmq_pkg; drives the write and read ports of hwmq_bin_mem.
`timescale 1ns / 1ps

module hwmq_ctrl
    import hwmq_pkg::*;
#(
    parameter int MAX_BINS    = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [OPCODE_W-1:0]          in_opcode,
    input  logic [BIN_INDEX_W-1:0]       in_bin_index,
    output logic                         res_valid,
    input  logic                         res_ready,
    output result_t                      res,
    output logic                         mem_wr_en,
    output logic [$clog2(MAX_BINS)-1:0]  mem_wr_addr,
    output logic [COUNT_WIDTH-1:0]       mem_wr_data,
    output logic                         mem_rd_en,
    output logic [$clog2(MAX_BINS)-1:0]  mem_rd_addr,
    input  logic [COUNT_WIDTH-1:0]       mem_rd_data
);

    localparam int AW = $clog2(MAX_BINS);
    localparam int NW = $clog2(MAX_BINS + 1);
    localparam int CW = (NW > BIN_INDEX_W) ? NW : BIN_INDEX_W;
    localparam int XW = (COUNT_WIDTH > CLEAR_VALUE_W) ? COUNT_WIDTH : CLEAR_VALUE_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [5:0] {
        ST_INIT = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_REC  = 6'b000100,
        ST_CLR  = 6'b001000,
        ST_QRY  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] best_cnt_reg, best_cnt_next;
    logic [NW-1:0]          best_state_reg, best_state_next;
    logic                   status_reg, status_next;

    logic [CW-1:0]          n_bins;
    logic [CW-1:0]          bins_ext;
    logic [CW-1:0]          idx_ext;
    logic [AW-1:0]          rec_addr;
    logic                   idx_bad;
    logic                   last_bin;
    logic [XW-1:0]          clr_ext;
    logic [COUNT_WIDTH-1:0] clr_val;
    logic                   accept;

    // Active bin count, capped at the table size
    assign bins_ext = CW'(cfg.bins_in_use);
    assign n_bins   = (bins_ext > CW'(MAX_BINS)) ? CW'(MAX_BINS) : bins_ext;

    // Record index check and zero-based address
    assign idx_ext  = CW'(in_bin_index);
    assign idx_bad  = (idx_ext == '0) || (idx_ext > n_bins);
    assign rec_addr = AW'(idx_ext - CW'(1));

    // Last active bin of a walk
    assign last_bin = (CW'(cnt_reg) == (n_bins - CW'(1)));

    // Clear value, saturated at the counter maximum
    assign clr_ext = XW'(cfg.clear_value);
    assign clr_val = (clr_ext > XW'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(clr_ext);

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Result presented in the done state
    assign res_valid       = (state_reg == ST_DONE);
    assign res.mode_state  = MODE_STATE_W'(best_state_reg);
    assign res.mode_count  = MODE_COUNT_W'(best_cnt_reg);
    assign res.status      = status_reg;

    // Next-state and memory port logic
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        best_cnt_next   = best_cnt_reg;
        best_state_next = best_state_reg;
        status_next     = status_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cnt_reg;
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = cnt_reg;

        case (state_reg)
            ST_INIT:
            begin
                // zero every entry once after reset
                mem_wr_en = 1'b1;
                if (cnt_reg == AW'(MAX_BINS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    best_cnt_next   = '0;
                    best_state_next = '0;
                    status_next     = 1'b0;
                    cnt_next        = '0;
                    case (opcode_t'(in_opcode))
                        OP_RECORD:
                        begin
                            if (idx_bad)
                            begin
                                status_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = rec_addr;
                                cnt_next    = rec_addr;
                                state_next  = ST_REC;
                            end
                        end
                        OP_CLEAR:
                        begin
                            state_next = (n_bins == '0) ? ST_DONE : ST_CLR;
                        end
                        OP_QUERY:
                        begin
                            if (n_bins == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                state_next  = ST_QRY;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_REC:
            begin
                // saturating increment of the fetched count
                mem_wr_en   = 1'b1;
                mem_wr_data = (mem_rd_data == CNT_MAX) ? CNT_MAX
                                                       : mem_rd_data + COUNT_WIDTH'(1);
                state_next  = ST_DONE;
            end

            ST_CLR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = clr_val;
                if (last_bin)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            ST_QRY:
            begin
                // data for bin cnt_reg arrives; strict compare keeps the first maximum
                if (mem_rd_data > best_cnt_reg)
                begin
                    best_cnt_next   = mem_rd_data;
                    best_state_next = NW'(cnt_reg) + NW'(1);
                end
                if (last_bin)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cnt_reg + AW'(1);
                    cnt_next    = cnt_reg + AW'(1);
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        best_cnt_reg   <= best_cnt_next;
        best_state_reg <= best_state_next;
        status_reg     <= status_next;
    end

endmodule

[rtl/core/histogram_with_mode_query.sv]
// Histogram with mode query. Record: read, write back, hand-off for each word.
// Clear and query each walk the n active bins of the bin memory in turn. Out-of-range
// record, no-op, or zero active bins go straight to the result.
// The result is registered into m_tdata once the output slot is free; a new word
// is accepted while the previous result waits. After reset the bin memory is zeroed
// in a sweep during which s_tready stays low; config writes still land.
`timescale 1ns / 1ps

module histogram_with_mode_query
    import hwmq_pkg::*;
#(
    parameter int MAX_BINS    = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // opcode[1:0], bin_index[10:2], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // mode_state[8:0], mode_count[40:9],
                                             // status[41], zero pad
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_BINS);

    cfg_t                   cfg_reg;
    result_t                out_reg;
    logic                   out_valid_reg;
    logic                   slot_free;
    logic                   res_valid;
    result_t                res;
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [COUNT_WIDTH-1:0] mem_wr_data;
    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic [COUNT_WIDTH-1:0] mem_rd_data;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bins_in_use <= BINS_IN_USE_W'(256);
            cfg_reg.clear_value <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BINS_IN_USE: cfg_reg.bins_in_use <= BINS_IN_USE_W'(cfg_data);
                CFG_CLEAR_VALUE: cfg_reg.clear_value <= CLEAR_VALUE_W'(cfg_data);
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    hwmq_bin_mem #(
        .DEPTH (MAX_BINS),
        .WIDTH (COUNT_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    hwmq_ctrl #(
        .MAX_BINS    (MAX_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_opcode    (s_tdata[1:0]),
        .in_bin_index (s_tdata[10:2]),
        .res_valid    (res_valid),
        .res_ready    (slot_free),
        .res          (res),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    // Output register: loads when empty or being drained
    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule

[dv/tb_histogram_with_mode_query.sv]
`timescale 1ns / 1ps
// Self-checking testbench for histogram_with_mode_query: stream driver and result monitor
// around the block, every result word checked against an in-bench histogram predictor.
// Depends on hwmq_pkg and the block RTL only.

module tb_histogram_with_mode_query;
    import hwmq_pkg::*;

    localparam int          NUM_BINS     = 256;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 8;

    // One input word: opcode in the low bits, bin index above it
    typedef struct packed {
        logic [BIN_INDEX_W-1:0] bin_index;
        opcode_t                opcode;
    } hist_word_t;

    localparam int WORD_W = $bits(hist_word_t);
    localparam int RES_W  = $bits(result_t);

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // opcode[1:0], bin_index[10:2], zero pad
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // mode_state[8:0], mode_count[40:9],
                                             // status[41], zero pad
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: bin counters and the live configuration
    logic [MODE_COUNT_W-1:0]  bin_tally [NUM_BINS];
    logic [BINS_IN_USE_W-1:0] bins_cfg;
    logic [CLEAR_VALUE_W-1:0] clear_cfg;

    hist_word_t word_q [$];           // words waiting to be sent
    result_t    mode_results_q [$];   // predicted results, oldest first

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    histogram_with_mode_query i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Active bins, saturated at the table size
    function automatic int unsigned active_bins();
        return (bins_cfg > NUM_BINS) ? NUM_BINS : int'(bins_cfg);
    endfunction

    // Apply one word to the histogram and return the result it produces
    function automatic result_t histo_apply(hist_word_t w);
        result_t     r;
        int unsigned n;
        r = '0;
        n = active_bins();
        case (w.opcode)
            OP_RECORD:
            begin
                if (w.bin_index == 0 || w.bin_index > n)
                    r.status = 1'b1;
                else if (bin_tally[w.bin_index - 1] != COUNT_MAX)
                    bin_tally[w.bin_index - 1] = bin_tally[w.bin_index - 1] + 1'b1;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < n; i++)
                    bin_tally[i] = MODE_COUNT_W'(clear_cfg);
            end
            OP_QUERY:
            begin
                // first strictly larger count wins, so ties go to the lower bin
                for (int i = 0; i < n; i++)
                begin
                    if (bin_tally[i] > r.mode_count)
                    begin
                        r.mode_count = bin_tally[i];
                        r.mode_state = MODE_STATE_W'(i + 1);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Random word: mostly in-range records, with clears, queries and noise mixed in
    function automatic hist_word_t random_word(int unsigned n);
        hist_word_t  w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        w.bin_index = BIN_INDEX_W'($urandom_range(0, 511));
        if (pick < 65)
        begin
            w.opcode = OP_RECORD;
            if (n > 0 && $urandom_range(0, 9) != 0)
                w.bin_index = BIN_INDEX_W'($urandom_range(1, n));
        end
        else if (pick < 75)
            w.opcode = OP_CLEAR;
        else if (pick < 95)
            w.opcode = OP_QUERY;
        else
            w.opcode = OP_NOP;
        return w;
    endfunction

    task automatic report_mismatch(string field, logic [M_TDATA_W-1:0] got,
                                   logic [M_TDATA_W-1:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic push_word(opcode_t op, logic [BIN_INDEX_W-1:0] idx);
        hist_word_t w;
        w.opcode    = op;
        w.bin_index = idx;
        word_q.push_back(w);
    endtask

    task automatic push_random(int count);
        for (int i = 0; i < count; i++)
            word_q.push_back(random_word(active_bins()));
    endtask

    // Hold until every queued word is sent and every result has come back
    task automatic drain_results();
        while (word_q.size() != 0 || s_tvalid || mode_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write, only called while the block is idle
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_BINS_IN_USE)
            bins_cfg = value[BINS_IN_USE_W-1:0];
        else
            clear_cfg = value[CLEAR_VALUE_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stream driver: present the next word once the current one is taken
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (s_tvalid)
                mode_results_q.push_back(histo_apply(hist_word_t'(s_tdata[WORD_W-1:0])));
            if (word_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tdata  <= {{(S_TDATA_W - WORD_W){1'b0}}, word_q.pop_front()};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result monitor: random backpressure, field-by-field compare
    always @(posedge clk)
    begin : result_mon
        result_t got_r;
        result_t want_r;
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r = result_t'(m_tdata[RES_W-1:0]);
            if (mode_results_q.size() == 0)
                report_mismatch("unexpected result word", m_tdata, '0);
            else
            begin
                want_r = mode_results_q.pop_front();
                if (got_r.mode_state !== want_r.mode_state)
                    report_mismatch("mode_state", got_r.mode_state, want_r.mode_state);
                if (got_r.mode_count !== want_r.mode_count)
                    report_mismatch("mode_count", got_r.mode_count, want_r.mode_count);
                if (got_r.status !== want_r.status)
                    report_mismatch("status", got_r.status, want_r.status);
                if (m_tdata[M_TDATA_W-1:RES_W] !== '0)
                    report_mismatch("tdata pad", m_tdata[M_TDATA_W-1:RES_W], '0);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, mode_results_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        for (int i = 0; i < NUM_BINS; i++)
            bin_tally[i] = '0;
        bins_cfg  = BINS_IN_USE_W'(NUM_BINS);
        clear_cfg = '0;
        send_idle_pct = 31;
        recv_idle_pct = 58;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset config: empty query, range edges, tied mode going to the lower bin, no-op, clear to zero
        push_word(OP_QUERY,  9'd0);
        push_word(OP_RECORD, 9'd0);
        push_word(OP_RECORD, 9'd257);
        push_word(OP_RECORD, 9'd511);
        push_word(OP_RECORD, 9'd256);
        push_word(OP_RECORD, 9'd1);
        push_word(OP_RECORD, 9'd1);
        push_word(OP_RECORD, 9'd256);
        push_word(OP_QUERY,  9'd0);
        push_word(OP_NOP,    9'd511);
        push_word(OP_CLEAR,  9'd0);
        push_word(OP_QUERY,  9'd0);
        drain_results();

        // No active bins: every record out of range, clear does nothing
        write_reg(CFG_BINS_IN_USE, 16'd0);
        write_reg(CFG_CLEAR_VALUE, 16'hFFFF);
        push_word(OP_RECORD, 9'd1);
        push_word(OP_CLEAR,  9'd0);
        push_word(OP_QUERY,  9'd0);
        drain_results();

        // Bins in use beyond the table saturate at the table size
        write_reg(CFG_BINS_IN_USE, 16'd511);
        push_word(OP_RECORD, 9'd256);
        push_word(OP_RECORD, 9'd257);
        push_word(OP_QUERY,  9'd0);
        drain_results();

        // Single bin: clear leaves the inactive bins alone
        write_reg(CFG_BINS_IN_USE, 16'd1);
        push_word(OP_CLEAR,  9'd0);
        push_word(OP_RECORD, 9'd1);
        push_word(OP_RECORD, 9'd2);
        push_word(OP_QUERY,  9'd0);
        drain_results();

        // Whole table again: the untouched bin must still hold its count
        write_reg(CFG_BINS_IN_USE, 16'd256);
        push_word(OP_QUERY, 9'd0);
        drain_results();

        // Random, sender 31% idle / receiver 58%, with a full drain halfway
        write_reg(CFG_BINS_IN_USE, 16'd16);
        write_reg(CFG_CLEAR_VALUE, 16'd5);
        push_random(125);
        drain_results();
        push_random(125);
        drain_results();

        // Random, idling swapped, full table
        send_idle_pct = 58;
        recv_idle_pct = 31;
        write_reg(CFG_BINS_IN_USE, 16'd256);
        write_reg(CFG_CLEAR_VALUE, 16'd1000);
        push_random(250);
        drain_results();

        // Random, back to back, few bins and the largest clear value
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_BINS_IN_USE, 16'd3);
        write_reg(CFG_CLEAR_VALUE, 16'hFFFF);
        push_random(250);
        drain_results();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
rtl/core/hwmq_pkg.sv
rtl/core/hwmq_bin_mem.sv
rtl/core/hwmq_ctrl.sv
rtl/core/histogram_with_mode_query.sv
dv/tb_histogram_with_mode_query.sv
